// ----- hdl/glyph_lru_cache_core_assert.svh -----
// Assertion macros for the glyph cache core.
// Expects clk and rst in the scope of the file that includes it.
`ifndef GLYPH_LRU_CACHE_CORE_ASSERT_SVH
`define GLYPH_LRU_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define GLC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glyph cache assertion failed");

// Next-cycle implication, off during reset.
`define GLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glyph cache assertion failed");

`endif

// ----- hdl/glc_pkg.sv -----
// Shared types, codes and helpers of the glyph cache.
// No dependencies.
package glc_pkg;

  localparam int KEY_W    = 64;
  localparam int FACE_W   = 16;
  localparam int GLYPH_W  = 32;
  localparam int SIZE_W   = 16;
  localparam int HANDLE_W = 32;
  localparam int COUNT_W  = 9;
  localparam int CFG_W    = 16;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_TRIM   = 2'd2;

  localparam logic [1:0] REL_NONE      = 2'd0;
  localparam logic [1:0] REL_OVERWRITE = 2'd1;
  localparam logic [1:0] REL_EVICT     = 2'd2;

  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_BUILTIN  = 2'd1;
  localparam logic [1:0] CFG_DEFAULT  = 2'd2;

  function automatic logic [KEY_W-1:0] pack_key(input logic [FACE_W-1:0] face,
                                                input logic [GLYPH_W-1:0] glyph,
                                                input logic [SIZE_W-1:0] size);
    return {face, glyph, size};
  endfunction

endpackage

// ----- hdl/glc_in_if.sv -----
// Request channel of the glyph cache: valid/ready and the request fields.
// Depends on glc_pkg.
interface glc_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       opcode;
  logic [glc_pkg::FACE_W-1:0]       face_number;
  logic [glc_pkg::GLYPH_W-1:0]      glyph_number;
  logic [glc_pkg::SIZE_W-1:0]       px_size;
  logic [glc_pkg::HANDLE_W-1:0]     bitmap_handle;

  modport source (output valid, opcode, face_number, glyph_number, px_size,
                  bitmap_handle, input ready);
  modport sink (input valid, opcode, face_number, glyph_number, px_size,
                bitmap_handle, output ready);
endinterface

// ----- hdl/glc_out_if.sv -----
// Result channel of the glyph cache: valid/ready and the result fields.
// Depends on glc_pkg.
interface glc_out_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [glc_pkg::HANDLE_W-1:0]     stored_handle;
  logic [1:0]                       released_kind;
  logic [glc_pkg::FACE_W-1:0]       released_face;
  logic [glc_pkg::GLYPH_W-1:0]      released_glyph;
  logic [glc_pkg::SIZE_W-1:0]       released_size;
  logic [glc_pkg::HANDLE_W-1:0]     released_handle;
  logic [glc_pkg::COUNT_W-1:0]      entry_count;

  modport source (output valid, hit, stored_handle, released_kind, released_face,
                  released_glyph, released_size, released_handle, entry_count,
                  input ready);
  modport sink (input valid, hit, stored_handle, released_kind, released_face,
                released_glyph, released_size, released_handle, entry_count,
                output ready);
endinterface

// ----- hdl/glc_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module glc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/glyph_lru_cache_core.sv -----
// Top level of the glyph cache: control sequencer around one entry RAM.
// Depends on glc_pkg, glc_in_if, glc_out_if, glc_ram and the assertion header.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+--------------------------------------
//  in_ch    | in  | valid/ready transfer  | opcode, face, glyph, size, handle
//  out_ch   | out | valid/ready transfer  | hit, handles, released key, count
//  cfg      | in  | cfg_we, no back-press | cfg_index, cfg_data
//
// An item runs through the key sweep, the decision, the recency read-modify-write
// sweep, the final write and the result load. The recency sweep is skipped on a
// lookup miss, an insert of a new key below capacity, a trim at or below capacity
// and an unused opcode. The entry RAM has a single read port, so each sweep reads
// the held entries one by one. The block returns to idle before the next transfer.
// Reset is synchronous; the held-entry count returns to zero, so no clearing
// pass is needed. The result register holds while out_ch stalls; the next
// item is taken as soon as the previous one's result is registered.
`include "glyph_lru_cache_core_assert.svh"

module glyph_lru_cache_core #(
  parameter int ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [glc_pkg::CFG_W-1:0]  cfg_data,
  glc_in_if.sink                     in_ch,
  glc_out_if.source                  out_ch
);
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int XW = (CW > glc_pkg::COUNT_W) ? CW : glc_pkg::COUNT_W;
  localparam int DW = glc_pkg::KEY_W + glc_pkg::HANDLE_W + AW;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_RANK, S_FINAL, S_OUT} state_t;
  state_t state;

  // configuration
  logic [glc_pkg::COUNT_W-1:0]  capacity;
  logic [glc_pkg::FACE_W-1:0]   builtin_face;
  logic [glc_pkg::FACE_W-1:0]   default_face;

  // item in flight
  logic [1:0]                   op;
  logic [glc_pkg::KEY_W-1:0]    key;
  logic [glc_pkg::HANDLE_W-1:0] hdl;
  logic [CW-1:0]                cnt;
  logic [CW-1:0]                cnt_next;
  logic [CW-1:0]                sc;
  logic                         p_v;
  logic [AW-1:0]                p_idx;

  // sweep findings: matching entry, least recent entry, last entry
  logic                         match;
  logic [AW-1:0]                m_idx;
  logic [AW-1:0]                m_rank;
  logic [glc_pkg::HANDLE_W-1:0] m_hdl;
  logic [AW-1:0]                v_idx;
  logic [glc_pkg::KEY_W-1:0]    v_key;
  logic [glc_pkg::HANDLE_W-1:0] v_hdl;
  logic [glc_pkg::KEY_W-1:0]    l_key;
  logic [glc_pkg::HANDLE_W-1:0] l_hdl;
  logic [AW-1:0]                l_rank;

  // rank pass and final write
  logic [AW-1:0]                thr;
  logic                         tgt_v;
  logic [glc_pkg::HANDLE_W-1:0] tgt_hdl;
  logic                         fin_we;
  logic [AW-1:0]                fin_addr;
  logic [DW-1:0]                fin_data;

  // decision taken from the sweep findings
  logic                         d_hit;
  logic [glc_pkg::HANDLE_W-1:0] d_sth;
  logic [1:0]                   d_kind;
  logic [glc_pkg::KEY_W-1:0]    d_key;
  logic [glc_pkg::HANDLE_W-1:0] d_hdl;
  logic [AW-1:0]                d_thr;
  logic                         d_tgt_v;
  logic [glc_pkg::HANDLE_W-1:0] d_tgt_hdl;
  logic                         d_fin_we;
  logic [AW-1:0]                d_fin_addr;
  logic [DW-1:0]                d_fin_data;
  logic [CW-1:0]                d_cnt;
  logic                         d_rank;

  // result under construction and result register
  logic                         r_hit;
  logic [glc_pkg::HANDLE_W-1:0] r_sth;
  logic [1:0]                   r_kind;
  logic [glc_pkg::KEY_W-1:0]    r_key;
  logic [glc_pkg::HANDLE_W-1:0] r_hdl;
  logic                         ov;
  logic                         o_hit;
  logic [glc_pkg::HANDLE_W-1:0] o_sth;
  logic [1:0]                   o_kind;
  logic [glc_pkg::KEY_W-1:0]    o_key;
  logic [glc_pkg::HANDLE_W-1:0] o_hdl;
  logic [glc_pkg::COUNT_W-1:0]  o_cnt;

  // RAM ports
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [DW-1:0]                wdata;
  logic [AW-1:0]                raddr;
  logic [DW-1:0]                rdata;

  logic [glc_pkg::KEY_W-1:0]    rd_key;
  logic [glc_pkg::HANDLE_W-1:0] rd_hdl;
  logic [AW-1:0]                rd_rank;
  logic [AW-1:0]                new_rank;
  logic [glc_pkg::HANDLE_W-1:0] new_hdl;
  logic [CW-1:0]                cnt_m1;
  logic [XW-1:0]                cnt_x;
  logic [XW-1:0]                ecap_x;
  logic [XW-1:0]                cnt_next_x;
  logic                         issue;
  logic                         in_xfer;
  logic [glc_pkg::FACE_W-1:0]   face_sub;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  assign rd_key  = rdata[DW-1 -: glc_pkg::KEY_W];
  assign rd_hdl  = rdata[AW +: glc_pkg::HANDLE_W];
  assign rd_rank = rdata[AW-1:0];
  assign cnt_m1  = cnt - CW'(1);
  assign cnt_x   = XW'(cnt);
  assign cnt_next_x = XW'(cnt_next);

  // capacity zero or above the store means the whole store
  always_comb begin
    if (capacity == '0 || XW'(capacity) > XW'(ENTRIES)) begin
      ecap_x = XW'(ENTRIES);
    end else begin
      ecap_x = XW'(capacity);
    end
  end

  // face zero takes the substitute: default face on lookup (builtin if default is zero), builtin otherwise
  always_comb begin
    face_sub = in_ch.face_number;
    if (in_ch.face_number == '0) begin
      if (in_ch.opcode == glc_pkg::OP_LOOKUP && default_face != '0) begin
        face_sub = default_face;
      end else begin
        face_sub = builtin_face;
      end
    end
  end

  // sweep address: one read per cycle while entries remain
  assign issue = (state == S_SCAN || state == S_RANK) && (sc < cnt);
  assign raddr = sc[AW-1:0];

  // decide the outcome once the key sweep is done
  always_comb begin
    d_hit      = 1'b0;
    d_sth      = '0;
    d_kind     = glc_pkg::REL_NONE;
    d_key      = '0;
    d_hdl      = '0;
    d_thr      = '0;
    d_tgt_v    = 1'b0;
    d_tgt_hdl  = hdl;
    d_fin_we   = 1'b0;
    d_fin_addr = v_idx;
    d_fin_data = {key, hdl, cnt_m1[AW-1:0]};
    d_cnt      = cnt;
    d_rank     = 1'b0;
    case (op)
      glc_pkg::OP_LOOKUP: begin
        if (match) begin
          d_hit     = 1'b1;
          d_sth     = m_hdl;
          d_thr     = m_rank;
          d_tgt_v   = 1'b1;
          d_tgt_hdl = m_hdl;
          d_rank    = 1'b1;
        end
      end
      glc_pkg::OP_INSERT: begin
        d_sth = hdl;
        if (match) begin
          d_hit   = 1'b1;
          d_kind  = glc_pkg::REL_OVERWRITE;
          d_key   = key;
          d_hdl   = m_hdl;
          d_thr   = m_rank;
          d_tgt_v = 1'b1;
          d_rank  = 1'b1;
        end else if (cnt_x >= ecap_x) begin
          // evict the least recent entry and reuse its slot on top
          d_kind   = glc_pkg::REL_EVICT;
          d_key    = v_key;
          d_hdl    = v_hdl;
          d_fin_we = 1'b1;
          d_rank   = 1'b1;
        end else begin
          d_fin_we   = 1'b1;
          d_fin_addr = cnt[AW-1:0];
          d_fin_data = {key, hdl, cnt[AW-1:0]};
          d_cnt      = cnt + CW'(1);
        end
      end
      glc_pkg::OP_TRIM: begin
        if (cnt_x > ecap_x) begin
          // evict, then move the last entry into the hole
          d_kind     = glc_pkg::REL_EVICT;
          d_key      = v_key;
          d_hdl      = v_hdl;
          d_fin_we   = (v_idx != cnt_m1[AW-1:0]);
          d_fin_data = {l_key, l_hdl, l_rank - AW'(1)};
          d_cnt      = cnt_m1;
          d_rank     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // rank pass: drop ranks above the threshold, lift the touched entry to top
  always_comb begin
    new_rank = rd_rank;
    new_hdl  = rd_hdl;
    if (tgt_v && p_idx == m_idx) begin
      new_rank = cnt_m1[AW-1:0];
      new_hdl  = tgt_hdl;
    end else if (rd_rank > thr) begin
      new_rank = rd_rank - AW'(1);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = p_idx;
    wdata = {rd_key, new_hdl, new_rank};
    if (state == S_RANK && p_v) begin
      we = 1'b1;
    end else if (state == S_FINAL) begin
      we    = fin_we;
      waddr = fin_addr;
      wdata = fin_data;
    end
  end

  glc_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_entries (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      p_v          <= 1'b0;
      ov           <= 1'b0;
      capacity     <= '0;
      builtin_face <= glc_pkg::FACE_W'(1);
      default_face <= glc_pkg::FACE_W'(1);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          glc_pkg::CFG_CAPACITY: capacity     <= cfg_data[glc_pkg::COUNT_W-1:0];
          glc_pkg::CFG_BUILTIN:  builtin_face <= cfg_data;
          glc_pkg::CFG_DEFAULT:  default_face <= cfg_data;
          default: ;
        endcase
      end

      // raise valid when a result is loaded, drop it once transferred
      if (state == S_OUT && (!ov || out_ch.ready)) begin
        ov <= 1'b1;
      end else if (ov && out_ch.ready) begin
        ov <= 1'b0;
      end

      // advance the sweep pipeline
      if (issue) begin
        sc    <= sc + CW'(1);
        p_idx <= sc[AW-1:0];
        p_v   <= 1'b1;
      end else begin
        p_v   <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            op    <= in_ch.opcode;
            key   <= glc_pkg::pack_key(face_sub, in_ch.glyph_number, in_ch.px_size);
            hdl   <= in_ch.bitmap_handle;
            sc    <= '0;
            match <= 1'b0;
            state <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (p_v) begin
            if (rd_key == key) begin
              match  <= 1'b1;
              m_idx  <= p_idx;
              m_rank <= rd_rank;
              m_hdl  <= rd_hdl;
            end
            if (rd_rank == '0) begin
              v_idx <= p_idx;
              v_key <= rd_key;
              v_hdl <= rd_hdl;
            end
            if (p_idx == cnt_m1[AW-1:0]) begin
              l_key  <= rd_key;
              l_hdl  <= rd_hdl;
              l_rank <= rd_rank;
            end
          end
          if (sc == cnt && !p_v) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          r_hit    <= d_hit;
          r_sth    <= d_sth;
          r_kind   <= d_kind;
          r_key    <= d_key;
          r_hdl    <= d_hdl;
          thr      <= d_thr;
          tgt_v    <= d_tgt_v;
          tgt_hdl  <= d_tgt_hdl;
          fin_we   <= d_fin_we;
          fin_addr <= d_fin_addr;
          fin_data <= d_fin_data;
          cnt_next <= d_cnt;
          sc       <= '0;
          state    <= d_rank ? S_RANK : S_FINAL;
        end

        S_RANK: begin
          if (sc == cnt && !p_v) begin
            state <= S_FINAL;
          end
        end

        S_FINAL: begin
          cnt   <= cnt_next;
          state <= S_OUT;
        end

        S_OUT: begin
          if (!ov || out_ch.ready) begin
            o_hit  <= r_hit;
            o_sth  <= r_sth;
            o_kind <= r_kind;
            o_key  <= r_key;
            o_hdl  <= r_hdl;
            o_cnt  <= cnt_next_x[glc_pkg::COUNT_W-1:0];
            state  <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = ov;
  assign out_ch.hit             = o_hit;
  assign out_ch.stored_handle   = o_sth;
  assign out_ch.released_kind   = o_kind;
  assign out_ch.released_face   = o_key[glc_pkg::KEY_W-1 -: glc_pkg::FACE_W];
  assign out_ch.released_glyph  = o_key[glc_pkg::SIZE_W +: glc_pkg::GLYPH_W];
  assign out_ch.released_size   = o_key[glc_pkg::SIZE_W-1:0];
  assign out_ch.released_handle = o_hdl;
  assign out_ch.entry_count     = o_cnt;

  // held entries never exceed the store
  `GLC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_x <= XW'(ENTRIES))
  // the key sweep only reads; nothing may be written under it
  `GLC_ASSERT_NOW(a_scan_no_write, state == S_SCAN, !we)
  // an accepted item always starts the key sweep
  `GLC_ASSERT_NEXT(a_accept_scan, in_xfer, state == S_SCAN)
  // a count change happens only at the end of an item
  `GLC_ASSERT_NEXT(a_cnt_final, state != S_FINAL, cnt == $past(cnt))

endmodule
